/* design/ghs_pkg.sv */
// ----------------------------------------------------------------------------
// ghs_pkg: shared types and constants for the Gaussian heat-source density
// Mode codes, register indexes, datapath widths and the config/derived
// bundles passed between the blocks.
// ----------------------------------------------------------------------------
package ghs_pkg;

  // Source form
  typedef enum logic [1:0] {
    MODE_1D   = 2'd0,
    MODE_2D   = 2'd1,
    MODE_3D   = 2'd2,
    MODE_DISC = 2'd3
  } mode_t;

  // Register indexes
  localparam int IDX_W = 3;
  localparam logic [IDX_W-1:0] REG_MODE   = 3'd0;
  localparam logic [IDX_W-1:0] REG_POWER  = 3'd1;
  localparam logic [IDX_W-1:0] REG_EFF    = 3'd2;
  localparam logic [IDX_W-1:0] REG_RADIUS = 3'd3;
  localparam logic [IDX_W-1:0] REG_CX     = 3'd4;
  localparam logic [IDX_W-1:0] REG_CY     = 3'd5;
  localparam logic [IDX_W-1:0] REG_CZ     = 3'd6;

  // Datapath widths
  localparam int CFG_W  = 32;
  localparam int POS_W  = 32;
  localparam int A_W    = 33;  // |pos - centre|
  localparam int U_W    = 30;  // normalized distance, Q2.28
  localparam int EFF_W  = 17;
  localparam int PE_W   = 48;  // power * efficiency
  localparam int KC_W   = 31;
  localparam int T_W    = 79;  // power * efficiency * K
  localparam int E_W    = 33;  // exponential, Q1.32
  localparam int B_W    = 49;
  localparam int R2_W   = 64;
  localparam int R3_W   = 96;
  localparam int DENS_W = 48;

  // 2/pi and 6*sqrt(3)/pi^1.5 in Q1.30
  localparam logic [KC_W-1:0]  K2_Q30  = 31'd683565276;
  localparam logic [KC_W-1:0]  K3_Q30  = 31'd2003950283;
  localparam logic [EFF_W-1:0] EFF_ONE = 17'd65536;

  // Live register values used by the datapath
  typedef struct packed {
    mode_t             mode;
    logic [31:0]       power;
    logic [2:0][31:0]  centre;  // z, y, x
  } cfg_t;

  // Quantities derived from the registers
  typedef struct packed {
    logic [31:0]      r;    // radius, zero forced to one
    logic [33:0]      r3x;  // 3 * r
    logic [R2_W-1:0]  r2;
    logic [R3_W-1:0]  r3;
    logic [T_W-1:0]   t;    // power * eff * K
  } drv_t;

endpackage

/* design/gaussian_heat_source_density_top.sv */
// ----------------------------------------------------------------------------
// gaussian_heat_source_density_top: heat-source power density per point
// Gaussian (1D/2D/3D) or disc source evaluated for a stream of points.
//
//   channel   dir  handshake          payload
//   s_*       in   tvalid/tready      tdata: pos_x, pos_y, pos_z
//   m_*       out  tvalid/tready      tdata: density; tuser: saturated
//   cfg_*     in   cfg_we             cfg_index, cfg_data
//
// One point per cycle while the skid entry is empty; the pipeline depth is set
// mostly by the 48-stage density divider and the 15-stage distance divider.
// Reset clears the registers to their defaults and empties the pipeline.
// The pipeline advances as one unit; an output register plus a skid entry
// absorb a stalled sink, so s_tready drops only while the skid entry is full.
// ----------------------------------------------------------------------------
module gaussian_heat_source_density_top #(
  parameter int FRAC_BITS     = 16,
  parameter int EXP_LUT_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [95:0] s_tdata,    // pos_x [31:0], pos_y [63:32], pos_z [95:64]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,    // density [47:0]
  output logic [0:0]  m_tuser,    // saturated [0]
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int SH2   = 2 * FRAC_BITS - 16;
  localparam int SH3   = 3 * FRAC_BITS - 16;
  localparam int NUM_W = ghs_pkg::B_W + SH3;
  localparam int DW    = ghs_pkg::DENS_W;
  localparam int RW    = ghs_pkg::R3_W;

  ghs_pkg::cfg_t cfg;
  ghs_pkg::drv_t drv;

  logic en;

  // front stages
  logic [2:0][32:0] a_c, a1, a2, a3;
  logic [2:0][63:0] sq2;
  logic [2:0]       le2, act, far_v;
  logic             v1, v2, v3, far2, far3, in3;
  logic [65:0]      sqsum;

  // divider / exponent outputs
  logic             vu, ve;
  logic [2:0][29:0] u;
  logic [1:0]       side_u;
  logic [32:0]      e;
  logic             in_e;

  // scale stages
  logic             vb1, vb2, vb3, in_b1, in_b2, in_b3;
  logic [59:0]      p0, p1;
  logic [57:0]      p2;
  logic [111:0]     bsum;
  logic [48:0]      bq;
  logic [NUM_W-1:0] num;
  logic [RW-1:0]    den, top_x, rem_b3;
  logic [DW-1:0]    lo_b3;
  logic             ovf_c, ovf_b3;

  // divider results and output
  logic             vd, ovf_d, in_d, sat_c;
  logic [DW-1:0]    q_d, dens_c;
  logic             out_v, skid_v, push, pop;
  logic [DW:0]      out_d, skid_d;

  ghs_cfg u_cfg (
    .clk   (clk),
    .rst   (rst),
    .we    (cfg_we),
    .index (cfg_index),
    .data  (cfg_data),
    .cfg   (cfg),
    .drv   (drv)
  );

  assign en       = !skid_v;
  assign s_tready = en;
  assign act      = {cfg.mode == ghs_pkg::MODE_3D, cfg.mode != ghs_pkg::MODE_1D, 1'b1};

  // Absolute distance to the centre per axis
  always_comb begin
    logic [32:0] diff;
    for (int l = 0; l < 3; l++) begin
      diff   = {s_tdata[l*32+31], s_tdata[l*32 +: 32]} -
               {cfg.centre[l][31], cfg.centre[l]};
      a_c[l] = diff[32] ? (~diff + 33'd1) : diff;
    end
  end

  // Range checks on the registered distances
  always_comb begin
    for (int l = 0; l < 3; l++) far_v[l] = act[l] && ({1'b0, a1[l]} >= drv.r3x);
    sqsum = 66'(sq2[0]) + 66'(sq2[1]) + 66'(sq2[2]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v1 <= s_tvalid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  // Front: distance, squares for the disc test, far flag
  always_ff @(posedge clk) begin
    if (en) begin
      a1 <= a_c;
      for (int l = 0; l < 3; l++) begin
        sq2[l] <= 64'(a1[l][31:0]) * 64'(a1[l][31:0]);
        le2[l] <= (a1[l] <= {1'b0, drv.r});
      end
      far2 <= |far_v;
      a2   <= a1;
      in3  <= (&le2) && (sqsum <= 66'(drv.r2));
      far3 <= far2;
      a3   <= a2;
    end
  end

  ghs_udiv #(.SIDE_W(2)) u_udiv (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v3),
    .a         (a3),
    .r         (drv.r),
    .side_in   ({far3, in3}),
    .out_valid (vu),
    .u         (u),
    .side_out  (side_u)
  );

  ghs_exp #(
    .FRAC_BITS     (FRAC_BITS),
    .EXP_LUT_DEPTH (EXP_LUT_DEPTH),
    .SIDE_W        (1)
  ) u_exp (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (vu),
    .u         (u),
    .far       (side_u[1]),
    .mode      (cfg.mode),
    .side_in   (side_u[0]),
    .out_valid (ve),
    .e         (e),
    .side_out  (in_e)
  );

  // Peak scaling, numerator shift and overflow test
  always_comb begin
    bsum  = 112'(p0) + (112'(p1) << 27) + (112'(p2) << 54);
    num   = (cfg.mode == ghs_pkg::MODE_3D) ? (NUM_W'(bq) << SH3) : (NUM_W'(bq) << SH2);
    den   = (cfg.mode == ghs_pkg::MODE_3D) ? drv.r3 : RW'(drv.r2);
    top_x = RW'(num[NUM_W-1:DW]);
    ovf_c = (top_x >= den);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vb1 <= 1'b0;
      vb2 <= 1'b0;
      vb3 <= 1'b0;
    end else if (en) begin
      vb1 <= ve;
      vb2 <= vb1;
      vb3 <= vb2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p0     <= 60'(drv.t[26:0]) * 60'(e);
      p1     <= 60'(drv.t[53:27]) * 60'(e);
      p2     <= 58'(drv.t[78:54]) * 58'(e);
      in_b1  <= in_e;
      bq     <= bsum[110:62];
      in_b2  <= in_b1;
      rem_b3 <= ovf_c ? '0 : top_x;
      lo_b3  <= num[DW-1:0];
      ovf_b3 <= ovf_c;
      in_b3  <= in_b2;
    end
  end

  ghs_ddiv #(.SIDE_W(1)) u_ddiv (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (vb3),
    .rem_in    (rem_b3),
    .lo_in     (lo_b3),
    .ovf_in    (ovf_b3),
    .side_in   (in_b3),
    .den       (den),
    .out_valid (vd),
    .q         (q_d),
    .ovf       (ovf_d),
    .side_out  (in_d)
  );

  // Result select
  always_comb begin
    if (cfg.mode == ghs_pkg::MODE_DISC) begin
      dens_c = in_d ? DW'(cfg.power) : '0;
      sat_c  = 1'b0;
    end else begin
      dens_c = ovf_d ? '1 : q_d;
      sat_c  = ovf_d;
    end
  end

  assign push = en && vd;
  assign pop  = out_v && m_tready;

  // Output register with one skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_v  <= 1'b0;
      skid_v <= 1'b0;
    end else if (skid_v) begin
      if (pop) skid_v <= 1'b0;
    end else if (push) begin
      if (out_v && !pop) skid_v <= 1'b1;
      else               out_v  <= 1'b1;
    end else if (pop) begin
      out_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v) begin
      if (pop) out_d <= skid_d;
    end else if (push) begin
      if (out_v && !pop) skid_d <= {sat_c, dens_c};
      else               out_d  <= {sat_c, dens_c};
    end
  end

  assign m_tvalid   = out_v;
  assign m_tdata    = out_d[DW-1:0];
  assign m_tuser[0] = out_d[DW];

endmodule

/* design/ghs_cfg.sv */
// ----------------------------------------------------------------------------
// ghs_cfg: configuration registers
// Holds the seven registers and a short pipeline of derived products
// (r^2, r^3, power * efficiency * K).
// ----------------------------------------------------------------------------
module ghs_cfg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        we,
  input  logic [ghs_pkg::IDX_W-1:0]   index,
  input  logic [ghs_pkg::CFG_W-1:0]   data,
  output ghs_pkg::cfg_t               cfg,
  output ghs_pkg::drv_t               drv
);

  ghs_pkg::mode_t    mode;
  logic [31:0]       power;
  logic [16:0]       eff;
  logic [31:0]       radius;
  logic [31:0]       cx, cy, cz;

  logic [31:0]       r;
  logic [16:0]       eff_c;
  logic [30:0]       kc;
  logic [63:0]       r2;
  logic [47:0]       pe;
  logic [63:0]       r3lo, r3hi;
  logic [54:0]       tlo, thi;
  logic [95:0]       r3;
  logic [78:0]       t;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= ghs_pkg::MODE_1D;
      power  <= '0;
      eff    <= ghs_pkg::EFF_ONE;
      radius <= 32'd65536;
      cx     <= '0;
      cy     <= '0;
      cz     <= '0;
    end else if (we) begin
      unique case (index)
        ghs_pkg::REG_MODE:   mode   <= ghs_pkg::mode_t'(data[1:0]);
        ghs_pkg::REG_POWER:  power  <= data;
        ghs_pkg::REG_EFF:    eff    <= data[16:0];
        ghs_pkg::REG_RADIUS: radius <= data;
        ghs_pkg::REG_CX:     cx     <= data;
        ghs_pkg::REG_CY:     cy     <= data;
        ghs_pkg::REG_CZ:     cz     <= data;
        default: ;
      endcase
    end
  end

  // Clamp radius and efficiency, pick the mode constant
  always_comb begin
    r     = (radius == '0) ? 32'd1 : radius;
    eff_c = (eff > ghs_pkg::EFF_ONE) ? ghs_pkg::EFF_ONE : eff;
    kc    = (mode == ghs_pkg::MODE_3D) ? ghs_pkg::K3_Q30 : ghs_pkg::K2_Q30;
  end

  // Derived products, three register steps
  always_ff @(posedge clk) begin
    r2   <= 64'(r) * 64'(r);
    pe   <= 48'(power) * 48'(eff_c);
    r3lo <= 64'(r2[31:0]) * 64'(r);
    r3hi <= 64'(r2[63:32]) * 64'(r);
    tlo  <= 55'(pe[23:0]) * 55'(kc);
    thi  <= 55'(pe[47:24]) * 55'(kc);
    r3   <= 96'(r3lo) + {r3hi, 32'd0};
    t    <= 79'(tlo) + {thi, 24'd0};
  end

  always_comb begin
    cfg.mode   = mode;
    cfg.power  = power;
    cfg.centre = {cz, cy, cx};
    drv.r      = r;
    drv.r3x    = 34'(r) + {1'b0, r, 1'b0};
    drv.r2     = r2;
    drv.r3     = r3;
    drv.t      = t;
  end

endmodule

/* design/ghs_udiv.sv */
// ----------------------------------------------------------------------------
// ghs_udiv: distance normalizer
// Three lanes of a pipelined restoring divider, u = (a << 28) / r,
// two quotient bits per stage, fifteen stages.
// ----------------------------------------------------------------------------
module ghs_udiv #(
  parameter int SIDE_W = 2
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic [2:0][32:0]     a,
  input  logic [31:0]          r,
  input  logic [SIDE_W-1:0]    side_in,
  output logic                 out_valid,
  output logic [2:0][29:0]     u,
  output logic [SIDE_W-1:0]    side_out
);

  localparam int UW  = ghs_pkg::U_W;
  localparam int BPS = 2;
  localparam int ST  = UW / BPS;

  typedef struct packed {
    logic [UW-1:0] q;
    logic [31:0]   rem;
    logic [UW-1:0] bits;  // dividend bits still to shift in
  } lane_t;

  lane_t [2:0]       lane0;
  lane_t [2:0]       pipe [1:ST];
  logic [SIDE_W-1:0] side [1:ST];
  logic [ST-1:0]     vld;

  // BPS restoring steps
  function automatic lane_t dstep(lane_t x, logic [31:0] d);
    lane_t      y;
    logic [32:0] ext;
    logic        hit;
    y = x;
    for (int j = 0; j < BPS; j++) begin
      ext    = {y.rem, y.bits[UW-1]};
      y.bits = y.bits << 1;
      hit    = (ext >= {1'b0, d});
      if (hit) ext = ext - {1'b0, d};
      y.rem  = ext[31:0];
      y.q    = {y.q[UW-2:0], hit};
    end
    return y;
  endfunction

  // Quotient is below 2^30 for near points, so the top bits start as a >> 2
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      lane0[l].q    = '0;
      lane0[l].rem  = 32'(a[l][32:2]);
      lane0[l].bits = {a[l][1:0], 28'd0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (en) vld <= {vld[ST-2:0], in_valid};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side[1] <= side_in;
      for (int l = 0; l < 3; l++) pipe[1][l] <= dstep(lane0[l], r);
      for (int s = 1; s < ST; s++) begin
        side[s+1] <= side[s];
        for (int l = 0; l < 3; l++) pipe[s+1][l] <= dstep(pipe[s][l], r);
      end
    end
  end

  always_comb begin
    for (int l = 0; l < 3; l++) u[l] = pipe[ST][l].q;
  end
  assign out_valid = vld[ST-1];
  assign side_out  = side[ST];

endmodule

/* design/ghs_exp.sv */
// ----------------------------------------------------------------------------
// ghs_exp: Gaussian exponent
// Sum of squared distances, argument scaling and exp(-x) by table with
// linear interpolation. Six register stages.
// ----------------------------------------------------------------------------
module ghs_exp #(
  parameter int FRAC_BITS     = 16,
  parameter int EXP_LUT_DEPTH = 256,
  parameter int SIDE_W        = 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic [2:0][29:0]     u,
  input  logic                 far,
  input  ghs_pkg::mode_t       mode,
  input  logic [SIDE_W-1:0]    side_in,
  output logic                 out_valid,
  output logic [32:0]          e,
  output logic [SIDE_W-1:0]    side_out
);

  localparam int LAT   = 6;
  localparam int F4    = FRAC_BITS + 4;
  localparam int ARG_W = FRAC_BITS + 7;
  localparam int P_W   = F4 + $clog2(EXP_LUT_DEPTH);
  localparam int IDX_W = $clog2(EXP_LUT_DEPTH + 1);
  localparam int DP_W  = ghs_pkg::E_W + F4;
  localparam logic [63:0] Q62_ONE  = 64'd1 << 62;
  localparam logic [63:0] EXP_STEP = (Q62_ONE / EXP_LUT_DEPTH) << 4;

  typedef logic [EXP_LUT_DEPTH:0][32:0] tab_t;

  function automatic logic [63:0] mul62(input logic [63:0] x, input logic [63:0] y);
    logic [127:0] p;
    p = {64'd0, x} * {64'd0, y};
    return p[125:62];
  endfunction

  // exp(-16 i / depth) in Q1.32, built from a Taylor series of one step
  function automatic tab_t build_tab();
    logic [63:0] term;
    logic [63:0] base;
    logic [63:0] cur;
    tab_t        tab;
    term = Q62_ONE;
    base = Q62_ONE;
    cur  = Q62_ONE;
    for (int k = 1; k <= 24; k++) begin
      term = mul62(term, EXP_STEP) / 64'(k);
      if (k[0]) base = base - term;
      else      base = base + term;
    end
    for (int i = 0; i <= EXP_LUT_DEPTH; i++) begin
      tab[i] = 33'((cur + 64'd536870912) >> 30);
      cur    = mul62(cur, base);
    end
    return tab;
  endfunction

  localparam tab_t EXP_TAB = build_tab();

  logic [LAT-1:0]     vld;
  logic [SIDE_W-1:0]  side [LAT];
  logic [2:0]         act;
  logic [2:0][59:0]   sq;
  logic               far1, far2;
  logic [61:0]        ssum;
  logic [63:0]        ks;
  logic [ARG_W-1:0]   arg;
  logic [P_W-1:0]     p;
  logic               zero_c, zero3, zero4, zero5;
  logic [IDX_W-1:0]   idx3;
  logic [F4-1:0]      f3, f4;
  logic [32:0]        t0_4, t1_4, t0_5;
  logic [DP_W-1:0]    dp5;

  // Lanes that count for this mode
  assign act = {mode == ghs_pkg::MODE_3D, mode != ghs_pkg::MODE_1D, 1'b1};

  // Argument and table address
  always_comb begin
    ks     = (mode == ghs_pkg::MODE_3D) ? (64'(ssum) + (64'(ssum) << 1)) : (64'(ssum) << 1);
    arg    = ks[62:56-FRAC_BITS];
    p      = P_W'(arg[F4-1:0]) * P_W'(EXP_LUT_DEPTH);
    zero_c = far2 || (arg[ARG_W-1:F4] != '0);
  end

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (en) vld <= {vld[LAT-2:0], in_valid};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side[0] <= side_in;
      for (int s = 1; s < LAT; s++) side[s] <= side[s-1];
      // squares
      for (int l = 0; l < 3; l++) sq[l] <= act[l] ? 60'(u[l]) * 60'(u[l]) : '0;
      far1  <= far;
      // sum
      ssum  <= 62'(sq[0]) + 62'(sq[1]) + 62'(sq[2]);
      far2  <= far1;
      // address
      idx3  <= IDX_W'(p[P_W-1:F4]);
      f3    <= p[F4-1:0];
      zero3 <= zero_c;
      // table read
      t0_4  <= EXP_TAB[idx3];
      t1_4  <= EXP_TAB[idx3 + IDX_W'(1)];
      f4    <= f3;
      zero4 <= zero3;
      // slope times fraction
      dp5   <= DP_W'(t0_4 - t1_4) * DP_W'(f4);
      t0_5  <= t0_4;
      zero5 <= zero4;
      // interpolated value
      e     <= zero5 ? '0 : t0_5 - dp5[DP_W-1:F4];
    end
  end

  assign out_valid = vld[LAT-1];
  assign side_out  = side[LAT-1];

endmodule

/* design/ghs_ddiv.sv */
// ----------------------------------------------------------------------------
// ghs_ddiv: density divider
// Pipelined restoring divider, one quotient bit per stage, 48 stages.
// The dividend's low bits are shifted out as the quotient shifts in.
// ----------------------------------------------------------------------------
module ghs_ddiv #(
  parameter int SIDE_W = 1
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic [ghs_pkg::R3_W-1:0]    rem_in,
  input  logic [ghs_pkg::DENS_W-1:0]  lo_in,
  input  logic                        ovf_in,
  input  logic [SIDE_W-1:0]           side_in,
  input  logic [ghs_pkg::R3_W-1:0]    den,
  output logic                        out_valid,
  output logic [ghs_pkg::DENS_W-1:0]  q,
  output logic                        ovf,
  output logic [SIDE_W-1:0]           side_out
);

  localparam int DW = ghs_pkg::R3_W;
  localparam int QW = ghs_pkg::DENS_W;

  typedef struct packed {
    logic [DW-1:0] rem;
    logic [QW-1:0] lo;
  } st_t;

  st_t               st0;
  st_t               pipe [1:QW];
  logic              ovfs [1:QW];
  logic [SIDE_W-1:0] side [1:QW];
  logic [QW-1:0]     vld;

  function automatic st_t dstep(st_t x, logic [DW-1:0] d);
    st_t       y;
    logic [DW:0] ext;
    logic        hit;
    ext   = {x.rem, x.lo[QW-1]};
    hit   = (ext >= {1'b0, d});
    if (hit) ext = ext - {1'b0, d};
    y.rem = ext[DW-1:0];
    y.lo  = {x.lo[QW-2:0], hit};
    return y;
  endfunction

  assign st0.rem = rem_in;
  assign st0.lo  = lo_in;

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (en) vld <= {vld[QW-2:0], in_valid};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pipe[1] <= dstep(st0, den);
      ovfs[1] <= ovf_in;
      side[1] <= side_in;
      for (int s = 1; s < QW; s++) begin
        pipe[s+1] <= dstep(pipe[s], den);
        ovfs[s+1] <= ovfs[s];
        side[s+1] <= side[s];
      end
    end
  end

  assign out_valid = vld[QW-1];
  assign q         = pipe[QW].lo;
  assign ovf       = ovfs[QW];
  assign side_out  = side[QW];

endmodule

/* design/ghs_check.sv */
// ----------------------------------------------------------------------------
// ghs_check: port-level checks for the heat-source density block
// Output handshake, saturation value and flow control, bound to the top.
// ----------------------------------------------------------------------------
module ghs_check (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [47:0] m_tdata,
  input logic [0:0]  m_tuser
);

  // Stalled result stays offered
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result dropped while stalled");

  // Stalled result keeps its payload
  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // Saturated results carry the clip value
  a_sat_max: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata == 48'hFFFF_FFFF_FFFF)
    else $error("saturated without clip value");

  // Reset empties the output
  a_rst_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid after reset");

  // With the output empty the input is never back-pressured
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty output");

endmodule

bind gaussian_heat_source_density_top ghs_check u_ghs_check (.*);
